// ===== src/htwd_pkg.sv =====
package htwd_pkg;

  // Table geometry.
  localparam int NODE_COUNT  = 512;
  localparam int SYMBOL_BITS = 8;
  localparam int ADDR_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  // Fixed field widths of the request and result items.
  localparam int IDX_W = 9;
  localparam int SYM_W = 8;

  // Request types.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // Result status codes.
  localparam logic STAT_SYMBOL = 1'b0;
  localparam logic STAT_MISS   = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] node_index;
    logic [IDX_W-1:0] left_child;
    logic             has_left;
    logic [IDX_W-1:0] right_child;
    logic             has_right;
    logic [SYM_W-1:0] leaf_symbol;
    logic             code_bit;
  } htwd_req_t;

  typedef struct packed {
    logic             status;
    logic [SYM_W-1:0] symbol;
  } htwd_res_t;

  // One node table entry: both child links and the leaf symbol.
  typedef struct packed {
    logic                   has_left;
    logic [IDX_W-1:0]       left_child;
    logic                   has_right;
    logic [IDX_W-1:0]       right_child;
    logic [SYMBOL_BITS-1:0] sym;
  } htwd_node_t;

  // True when a node index names an entry of the table.
  function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < NODE_COUNT;
  endfunction

  // Memory address of a node index.
  function automatic logic [ADDR_W-1:0] node_addr(input logic [IDX_W-1:0] idx);
    return ADDR_W'(idx);
  endfunction

endpackage

// ===== src/huffman_tree_walk_decoder.sv =====
// Bit-serial Huffman decoder walking a code tree held in a node memory.
// Input channel (in_valid/in_ready/in_data): a load request writes one tree
// node (children with presence marks and leaf symbol); a decode request
// carries one code bit. Result channel (out_valid/out_ready/out_data): one
// result per decoded symbol or per missing child, none for loads or for
// bits that land on an inner node. cfg_we/cfg_data set the root node and
// restart the walk there.
// The current node's entry is held in a register. A load completes without
// leaving the idle state. A decode bit to an inner node needs one node
// memory read of the child. A bit that ends on a leaf needs the child read,
// then a reread of the root entry; its result is registered from the child
// entry as the reread starts. A missing child registers its result in the
// cycle after acceptance, then rereads the root. The node memory has a
// single read port with a registered read.
// After reset the root entry is fetched (IDLE, then FETCH) before in_ready rises.
// A result waits in the output register while out_ready is low; a new
// request is taken only when that register is free or being emptied.
module huffman_tree_walk_decoder
  import htwd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  htwd_req_t        in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output htwd_res_t        out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_LEAF  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] root_r, root_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  htwd_node_t       cur_word_r, cur_word_nxt;
  logic             cur_vld_r, cur_vld_nxt;
  logic             out_valid_r, out_valid_nxt;
  htwd_res_t        out_data_r, out_data_nxt;

  // Node memory.
  htwd_node_t       mem [NODE_COUNT];
  htwd_node_t       rdata_r;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic             wr_en;
  htwd_node_t       wr_word;

  logic             accept;
  logic             sel_has;
  logic [IDX_W-1:0] sel_idx;
  logic             child_ok;
  logic             rd_leaf;

  assign in_ready  = (state_r == ST_IDLE) && cur_vld_r && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Child chosen by the code bit from the current entry.
  assign sel_has  = in_data.code_bit ? cur_word_r.has_right : cur_word_r.has_left;
  assign sel_idx  = in_data.code_bit ? cur_word_r.right_child : cur_word_r.left_child;
  assign child_ok = sel_has && idx_in_range(sel_idx);
  assign rd_leaf  = !(rdata_r.has_left || rdata_r.has_right);

  // Entry written by a load request.
  always_comb begin
    wr_word.has_left    = in_data.has_left;
    wr_word.left_child  = in_data.left_child;
    wr_word.has_right   = in_data.has_right;
    wr_word.right_child = in_data.right_child;
    wr_word.sym         = SYMBOL_BITS'(in_data.leaf_symbol);
  end

  assign wr_en = accept && (in_data.req_type == REQ_LOAD) &&
                 idx_in_range(in_data.node_index);

  // Sequencer: walk control, memory read requests and the result register.
  always_comb begin
    state_nxt     = state_r;
    root_nxt      = root_r;
    cur_nxt       = cur_r;
    cur_word_nxt  = cur_word_r;
    cur_vld_nxt   = cur_vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = node_addr(cur_r);

    if (cfg_we) begin
      // A new root drops any partial walk.
      root_nxt    = cfg_data;
      cur_nxt     = cfg_data;
      cur_vld_nxt = 1'b0;
      state_nxt   = ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!cur_vld_r) begin
            rd_en     = 1'b1;
            rd_addr   = node_addr(cur_r);
            state_nxt = ST_FETCH;
          end else if (accept && (in_data.req_type == REQ_LOAD)) begin
            // Keep the held entry coherent when the current node is rewritten.
            if (wr_en && (in_data.node_index == cur_r)) begin
              cur_word_nxt = wr_word;
            end
          end else if (accept) begin
            if (child_ok) begin
              cur_nxt   = sel_idx;
              rd_en     = 1'b1;
              rd_addr   = node_addr(sel_idx);
              state_nxt = ST_LEAF;
            end else begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = STAT_MISS;
              out_data_nxt.symbol = '0;
              cur_nxt             = root_r;
              cur_vld_nxt         = 1'b0;
              rd_en               = 1'b1;
              rd_addr             = node_addr(root_r);
              state_nxt           = ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          // Entry of an index beyond the table reads as a node with no children.
          cur_word_nxt = idx_in_range(cur_r) ? rdata_r : '0;
          cur_vld_nxt  = 1'b1;
          state_nxt    = ST_IDLE;
        end
        ST_LEAF: begin
          if (rd_leaf) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = STAT_SYMBOL;
            out_data_nxt.symbol = SYM_W'(rdata_r.sym);
            cur_nxt             = root_r;
            cur_vld_nxt         = 1'b0;
            rd_en               = 1'b1;
            rd_addr             = node_addr(root_r);
            state_nxt           = ST_FETCH;
          end else begin
            cur_word_nxt = rdata_r;
            cur_vld_nxt  = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
        default: begin
          cur_vld_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      endcase
    end
  end

  // Node memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[node_addr(in_data.node_index)] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      root_r      <= '0;
      cur_r       <= '0;
      cur_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      cur_r       <= cur_nxt;
      cur_vld_r   <= cur_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_word_r <= cur_word_nxt;
    out_data_r <= out_data_nxt;
  end

  // A request is taken only with a valid held entry in the idle state.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == ST_IDLE) && cur_vld_r)
    else $error("request taken without a valid current entry");

  // The result slot is free whenever a leaf check resolves.
  a_leaf_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEAF) |-> !out_valid_r)
    else $error("leaf check with result register occupied");

  // A decode bit either reads the child or reports a miss at once.
  a_decode_path: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.req_type == REQ_DECODE) && !cfg_we) |=>
      (state_r == ST_LEAF) || (out_valid_r && (state_r == ST_FETCH)))
    else $error("decode bit took no path");

  // Loads never produce a result.
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.req_type == REQ_LOAD) && !out_valid_r) |=> !out_valid_r)
    else $error("load produced a result");

endmodule
